[rtl/lfu_mru_pkg.sv]
`default_nettype none

package lfu_mru_pkg;

  // Default geometry
  localparam int unsigned ENTRIES_DEF    = 64;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam int unsigned KEY_BITS_DEF   = 32;

  // Fixed field and state widths
  localparam int unsigned STAMP_W   = 48;
  localparam int unsigned CNT_OUT_W = 16;
  localparam int unsigned CAP_W     = 7;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Register index (word address)
  localparam logic [PADDR_W-3:0] REG_CAPACITY = 1'b0;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_ACCESS = 2'd0,
    KIND_PEEK   = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_e;

  // Status of one scan pass
  typedef struct packed {
    logic match_found;
    logic victim_found;
    logic free_found;
  } scan_flags_t;

endpackage

`default_nettype wire

[rtl/lfu_mru_scan.sv]
`default_nettype none

// Compare unit shared by every scan pass: looks at one entry per cycle and
// keeps the key match, the replacement victim and the first free slot.
module lfu_mru_scan import lfu_mru_pkg::*; #(
  parameter int unsigned ENTRIES    = ENTRIES_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          clear_i,
  input  wire logic                          strobe_i,
  input  wire logic [$clog2(ENTRIES)-1:0]    idx_i,
  input  wire logic                          valid_i,
  input  wire logic [KEY_BITS-1:0]           key_i,
  input  wire logic [COUNT_BITS-1:0]         count_i,
  input  wire logic [STAMP_W-1:0]            stamp_i,
  input  wire logic [KEY_BITS-1:0]           find_key_i,
  output scan_flags_t                        flags_o,
  output logic [$clog2(ENTRIES)-1:0]         match_idx_o,
  output logic [COUNT_BITS-1:0]              match_count_o,
  output logic [$clog2(ENTRIES)-1:0]         victim_idx_o,
  output logic [KEY_BITS-1:0]                victim_key_o,
  output logic [$clog2(ENTRIES)-1:0]         free_idx_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  scan_flags_t           flags_q, flags_d;
  logic [IDX_W-1:0]      match_idx_q, match_idx_d;
  logic [COUNT_BITS-1:0] match_cnt_q, match_cnt_d;
  logic [IDX_W-1:0]      vict_idx_q, vict_idx_d;
  logic [COUNT_BITS-1:0] vict_cnt_q, vict_cnt_d;
  logic [STAMP_W-1:0]    vict_stamp_q, vict_stamp_d;
  logic [KEY_BITS-1:0]   vict_key_q, vict_key_d;
  logic [IDX_W-1:0]      free_idx_q, free_idx_d;
  logic                  live;
  logic                  better;

  // Lower count wins; on equal count the newer stamp wins
  assign live   = strobe_i && valid_i;
  assign better = !flags_q.victim_found || (count_i < vict_cnt_q) ||
                  ((count_i == vict_cnt_q) && (stamp_i > vict_stamp_q));

  always_comb begin
    flags_d      = flags_q;
    match_idx_d  = match_idx_q;
    match_cnt_d  = match_cnt_q;
    vict_idx_d   = vict_idx_q;
    vict_cnt_d   = vict_cnt_q;
    vict_stamp_d = vict_stamp_q;
    vict_key_d   = vict_key_q;
    free_idx_d   = free_idx_q;
    if (clear_i) begin
      flags_d = '0;
    end else begin
      if (live && (key_i == find_key_i) && !flags_q.match_found) begin
        flags_d.match_found = 1'b1;
        match_idx_d         = idx_i;
        match_cnt_d         = count_i;
      end
      if (live && better) begin
        flags_d.victim_found = 1'b1;
        vict_idx_d           = idx_i;
        vict_cnt_d           = count_i;
        vict_stamp_d         = stamp_i;
        vict_key_d           = key_i;
      end
      if (strobe_i && !valid_i && !flags_q.free_found) begin
        flags_d.free_found = 1'b1;
        free_idx_d         = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    match_idx_q  <= match_idx_d;
    match_cnt_q  <= match_cnt_d;
    vict_idx_q   <= vict_idx_d;
    vict_cnt_q   <= vict_cnt_d;
    vict_stamp_q <= vict_stamp_d;
    vict_key_q   <= vict_key_d;
    free_idx_q   <= free_idx_d;
  end

  assign flags_o       = flags_q;
  assign match_idx_o   = match_idx_q;
  assign match_count_o = match_cnt_q;
  assign victim_idx_o  = vict_idx_q;
  assign victim_key_o  = vict_key_q;
  assign free_idx_o    = free_idx_q;

endmodule

`default_nettype wire

[rtl/lfu_mru_tiebreak_replacement.sv]
`default_nettype none

// Fully associative LFU replacement store with most-recent tie-break. Each
// item (access, peek or remove of a key) gives one result. The block takes one
// item at a time and stalls its input while busy. Every item runs one scan pass
// over all ENTRIES slots through a single shared compare unit, one slot per
// cycle from the key/count/stamp memories, then a drain state and a decision
// state. An access that misses while the store is at capacity evicts one
// victim in each decision state and rescans; more victims than one occur
// only after capacity was lowered below occupancy. The decision state waits
// while the previous result is still stalled at the output. Capacity is
// written over the APB port at byte address 0; values of zero act as one,
// values above ENTRIES act as ENTRIES.
module lfu_mru_tiebreak_replacement import lfu_mru_pkg::*; #(
  parameter int unsigned ENTRIES    = ENTRIES_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           kind_i,
  input  wire logic [KEY_BITS-1:0]  key_i,
  // output channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      hit_o,
  output logic                      evict_valid_o,
  output logic [KEY_BITS-1:0]       evict_key_o,
  output logic [CNT_OUT_W-1:0]      entry_count_o,
  // configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [PADDR_W-1:0]   paddr,
  input  wire logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]        prdata,
  output logic                      pready
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } state_e;

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [CAP_W-1:0] cap_q;
  logic             cap_sel;

  assign cap_sel = (paddr[PADDR_W-1:2] == REG_CAPACITY);
  assign pready  = 1'b1;
  assign prdata  = cap_sel ? PDATA_W'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && cap_sel) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // Effective capacity
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] limit;
  assign cap_ext = CMP_W'(cap_q);
  always_comb begin
    if (cap_ext == '0) begin
      limit = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      limit = CMP_W'(ENTRIES);
    end else begin
      limit = cap_ext;
    end
  end

  // ---------------------------------------------------------------------
  // Control and state registers
  // ---------------------------------------------------------------------
  state_e                state_q, state_d;
  logic [IDX_W-1:0]      rd_addr_q, rd_addr_d;
  logic                  s1_q;
  logic [IDX_W-1:0]      s1_idx_q;
  logic                  s1_valid_q;
  logic [ENTRIES-1:0]    valid_q, valid_d;
  logic [OCC_W-1:0]      occ_q, occ_d;
  logic [STAMP_W-1:0]    stamp_q, stamp_d;
  logic [1:0]            kind_q, kind_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic                  ev_flag_q, ev_flag_d;
  logic [KEY_BITS-1:0]   ev_key_q, ev_key_d;
  logic                  out_valid_q, out_valid_d;
  logic                  hit_q, hit_d;
  logic                  ev_valid_q, ev_valid_d;
  logic [KEY_BITS-1:0]   ev_out_q, ev_out_d;
  logic [CNT_OUT_W-1:0]  cnt_out_q, cnt_out_d;

  // Memory write port
  logic                  key_we;
  logic                  cs_we;
  logic [IDX_W-1:0]      wr_idx;
  logic [COUNT_BITS-1:0] wr_cnt;

  // Memory read data
  logic [KEY_BITS-1:0]   key_rd_q;
  logic [COUNT_BITS-1:0] cnt_rd_q;
  logic [STAMP_W-1:0]    stamp_rd_q;

  // Scan unit results
  logic                  scan_clear;
  scan_flags_t           flags;
  logic [IDX_W-1:0]      match_idx;
  logic [COUNT_BITS-1:0] match_cnt;
  logic [IDX_W-1:0]      vict_idx;
  logic [KEY_BITS-1:0]   vict_key;
  logic [IDX_W-1:0]      free_idx;

  logic                  in_fire;
  logic                  out_free;
  logic                  full;
  logic [COUNT_BITS-1:0] inc_cnt;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full       = CMP_W'(occ_q) >= limit;
  assign inc_cnt    = (match_cnt == '1) ? match_cnt : match_cnt + COUNT_BITS'(1);

  // Narrow or widen a count to the result field
  function automatic logic [CNT_OUT_W-1:0] to_out(input logic [COUNT_BITS-1:0] c);
    logic [COUNT_BITS+CNT_OUT_W-1:0] w;
    w = {{CNT_OUT_W{1'b0}}, c};
    return w[CNT_OUT_W-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    rd_addr_d   = rd_addr_q;
    valid_d     = valid_q;
    occ_d       = occ_q;
    stamp_d     = stamp_q;
    kind_d      = kind_q;
    key_d       = key_q;
    ev_flag_d   = ev_flag_q;
    ev_key_d    = ev_key_q;
    out_valid_d = out_valid_q && out_stall_i;
    hit_d       = hit_q;
    ev_valid_d  = ev_valid_q;
    ev_out_d    = ev_out_q;
    cnt_out_d   = cnt_out_q;
    key_we      = 1'b0;
    cs_we       = 1'b0;
    wr_idx      = match_idx;
    wr_cnt      = inc_cnt;
    scan_clear  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          kind_d     = kind_i;
          key_d      = key_i;
          ev_flag_d  = 1'b0;
          ev_key_d   = '0;
          rd_addr_d  = '0;
          scan_clear = 1'b1;
          state_d    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        rd_addr_d = rd_addr_q + IDX_W'(1);
        if (rd_addr_q == LAST_IDX) begin
          rd_addr_d = '0;
          state_d   = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        state_d = ST_DECIDE;
      end

      ST_DECIDE: begin
        if ((kind_q == KIND_ACCESS) && !flags.match_found && full &&
            flags.victim_found) begin
          // Evict one victim and run another pass
          valid_d[vict_idx] = 1'b0;
          occ_d             = occ_q - OCC_W'(1);
          if (!ev_flag_q) begin
            ev_flag_d = 1'b1;
            ev_key_d  = vict_key;
          end
          scan_clear = 1'b1;
          rd_addr_d  = '0;
          state_d    = ST_SCAN;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          hit_d       = 1'b0;
          ev_valid_d  = ev_flag_q;
          ev_out_d    = ev_key_q;
          cnt_out_d   = '0;
          state_d     = ST_IDLE;
          case (kind_q)
            KIND_ACCESS: begin
              if (flags.match_found) begin
                hit_d     = 1'b1;
                cs_we     = 1'b1;
                stamp_d   = stamp_q + STAMP_W'(1);
                cnt_out_d = to_out(inc_cnt);
              end else begin
                // Store full with nothing valid: occupancy restarts at zero
                if (full) begin
                  occ_d = '0;
                end
                if (flags.free_found) begin
                  wr_idx            = free_idx;
                  wr_cnt            = COUNT_BITS'(1);
                  key_we            = 1'b1;
                  cs_we             = 1'b1;
                  valid_d[free_idx] = 1'b1;
                  stamp_d           = stamp_q + STAMP_W'(1);
                  occ_d             = (full ? '0 : occ_q) + OCC_W'(1);
                  cnt_out_d         = to_out(COUNT_BITS'(1));
                end
              end
            end
            KIND_PEEK: begin
              hit_d = flags.match_found;
              if (flags.match_found) begin
                cnt_out_d = to_out(match_cnt);
              end
            end
            KIND_REMOVE: begin
              hit_d = flags.match_found;
              if (flags.match_found) begin
                valid_d[match_idx] = 1'b0;
                if (occ_q != '0) begin
                  occ_d = occ_q - OCC_W'(1);
                end
              end
            end
            default: begin
              hit_d = 1'b0;
            end
          endcase
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_addr_q   <= '0;
      s1_q        <= 1'b0;
      s1_idx_q    <= '0;
      s1_valid_q  <= 1'b0;
      valid_q     <= '0;
      occ_q       <= '0;
      stamp_q     <= '0;
      kind_q      <= '0;
      key_q       <= '0;
      ev_flag_q   <= 1'b0;
      ev_key_q    <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      ev_valid_q  <= 1'b0;
      ev_out_q    <= '0;
      cnt_out_q   <= '0;
    end else begin
      state_q     <= state_d;
      rd_addr_q   <= rd_addr_d;
      s1_q        <= (state_q == ST_SCAN);
      s1_idx_q    <= rd_addr_q;
      s1_valid_q  <= valid_q[rd_addr_q];
      valid_q     <= valid_d;
      occ_q       <= occ_d;
      stamp_q     <= stamp_d;
      kind_q      <= kind_d;
      key_q       <= key_d;
      ev_flag_q   <= ev_flag_d;
      ev_key_q    <= ev_key_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      ev_valid_q  <= ev_valid_d;
      ev_out_q    <= ev_out_d;
      cnt_out_q   <= cnt_out_d;
    end
  end

  // ---------------------------------------------------------------------
  // Entry memories: one write port, one registered read port
  // ---------------------------------------------------------------------
  logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_mem   [ENTRIES];
  logic [STAMP_W-1:0]    stamp_mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_idx] <= key_q;
    end
    key_rd_q <= key_mem[rd_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cs_we) begin
      cnt_mem[wr_idx] <= wr_cnt;
    end
    cnt_rd_q <= cnt_mem[rd_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cs_we) begin
      stamp_mem[wr_idx] <= stamp_q;
    end
    stamp_rd_q <= stamp_mem[rd_addr_q];
  end

  // ---------------------------------------------------------------------
  // Shared compare unit
  // ---------------------------------------------------------------------
  lfu_mru_scan #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS),
    .KEY_BITS   (KEY_BITS)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (scan_clear),
    .strobe_i      (s1_q),
    .idx_i         (s1_idx_q),
    .valid_i       (s1_valid_q),
    .key_i         (key_rd_q),
    .count_i       (cnt_rd_q),
    .stamp_i       (stamp_rd_q),
    .find_key_i    (key_q),
    .flags_o       (flags),
    .match_idx_o   (match_idx),
    .match_count_o (match_cnt),
    .victim_idx_o  (vict_idx),
    .victim_key_o  (vict_key),
    .free_idx_o    (free_idx)
  );

  // Result outputs
  assign out_valid_o   = out_valid_q;
  assign hit_o         = hit_q;
  assign evict_valid_o = ev_valid_q;
  assign evict_key_o   = ev_out_q;
  assign entry_count_o = cnt_out_q;

endmodule

`default_nettype wire

[tb/tb_lfu_mru_tiebreak_replacement.sv]
`default_nettype none

module tb_lfu_mru_tiebreak_replacement;
  import lfu_mru_pkg::*;

  localparam int NSLOT       = ENTRIES_DEF;
  localparam int KW          = KEY_BITS_DEF;
  localparam int CW          = COUNT_BITS_DEF;
  localparam int POOL        = 128;
  localparam int PHASE_ITEMS = 162;
  localparam int N_PHASES    = 12;
  localparam int HOLD_CYCLES = 600;
  localparam int STALL_LIMIT = 30000;
  localparam int TAIL_CYCLES = 100;

  // kind code with no operation behind it
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic          hit;
    logic          evict_valid;
    logic [KW-1:0] evict_key;
    logic [CNT_OUT_W-1:0] count;
  } lookup_res_t;

  typedef struct packed {
    logic             is_cfg;
    logic [CAP_W-1:0] cap;
    logic [1:0]       kind;
    logic [KW-1:0]    key;
    logic             typed;
    lookup_res_t      want;
  } stim_row_t;

  localparam lookup_res_t RES_NONE = '0;
  localparam lookup_res_t RES_NEW  = '{1'b0, 1'b0, 32'h0, 16'd1};
  localparam lookup_res_t RES_HIT2 = '{1'b1, 1'b0, 32'h0, 16'd2};
  localparam lookup_res_t RES_GONE = '{1'b1, 1'b0, 32'h0, 16'd0};

  // Directed stimulus; typed rows carry their result, the rest use the predictor
  localparam int N_DIR = 23;
  localparam stim_row_t DIR_TABLE [N_DIR] = '{
    '{1'b0, 7'd0,   KIND_PEEK,   32'h0000_0000, 1'b1, RES_NONE},
    '{1'b0, 7'd0,   KIND_REMOVE, 32'hFFFF_FFFF, 1'b1, RES_NONE},
    '{1'b0, 7'd0,   KIND_UNUSED, 32'h0000_0000, 1'b1, RES_NONE},
    '{1'b0, 7'd0,   KIND_ACCESS, 32'h0000_0000, 1'b1, RES_NEW},
    '{1'b0, 7'd0,   KIND_ACCESS, 32'h0000_0000, 1'b1, RES_HIT2},
    '{1'b0, 7'd0,   KIND_PEEK,   32'h0000_0000, 1'b1, RES_HIT2},
    '{1'b0, 7'd0,   KIND_ACCESS, 32'hFFFF_FFFF, 1'b1, RES_NEW},
    '{1'b0, 7'd0,   KIND_UNUSED, 32'hFFFF_FFFF, 1'b1, RES_NONE},
    '{1'b0, 7'd0,   KIND_REMOVE, 32'h0000_0000, 1'b1, RES_GONE},
    '{1'b0, 7'd0,   KIND_PEEK,   32'h0000_0000, 1'b1, RES_NONE},
    // two slots: tie on count one goes to the newest entry
    '{1'b1, 7'd2,   KIND_ACCESS, 32'h0000_0000, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   KIND_ACCESS, 32'h5555_5555, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   KIND_ACCESS, 32'hAAAA_AAAA, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   KIND_ACCESS, 32'hAAAA_AAAA, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   KIND_ACCESS, 32'h1234_5678, 1'b0, RES_NONE},
    // zero acts as one: the next miss evicts twice
    '{1'b1, 7'd0,   KIND_ACCESS, 32'h0000_0000, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   KIND_ACCESS, 32'h8000_0001, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   KIND_PEEK,   32'h8000_0001, 1'b0, RES_NONE},
    // above the slot count acts as the slot count
    '{1'b1, 7'd127, KIND_ACCESS, 32'h0000_0000, 1'b0, RES_NONE},
    '{1'b0, 7'd0,   KIND_REMOVE, 32'h8000_0001, 1'b1, RES_GONE},
    '{1'b0, 7'd0,   KIND_REMOVE, 32'h8000_0001, 1'b1, RES_NONE},
    '{1'b0, 7'd0,   KIND_ACCESS, 32'h7FFF_FFFE, 1'b0, RES_NONE},
    '{1'b1, 7'd64,  KIND_ACCESS, 32'h0000_0000, 1'b0, RES_NONE}
  };

  localparam logic [CAP_W-1:0] PHASE_CAPS [N_PHASES] = '{
    7'd64, 7'd8, 7'd1, 7'd0, 7'd127, 7'd3, 7'd64, 7'd2, 7'd100, 7'd16, 7'd5, 7'd64
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           kind;
  logic [KW-1:0]        key;
  logic                 out_valid;
  logic                 out_stall;
  logic                 hit;
  logic                 evict_valid;
  logic [KW-1:0]        evict_key;
  logic [CNT_OUT_W-1:0] entry_count;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  lfu_mru_tiebreak_replacement u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .kind_i         (kind),
    .key_i          (key),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .hit_o          (hit),
    .evict_valid_o  (evict_valid),
    .evict_key_o    (evict_key),
    .entry_count_o  (entry_count),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #6 clk = ~clk;

  // Shadow copy of the store
  logic [KW-1:0]      shadow_key  [NSLOT];
  logic               shadow_used [NSLOT];
  logic [CW-1:0]      shadow_freq [NSLOT];
  logic [STAMP_W-1:0] shadow_age  [NSLOT];
  logic [STAMP_W-1:0] age_clock;
  int                 shadow_fill;
  logic [CAP_W-1:0]   cap_reg;

  lookup_res_t   pending_results [$];
  logic [KW-1:0] key_pool [POOL];

  bit no_gaps  = 1'b0;
  bit hold_req = 1'b0;
  int n_errors = 0;
  int n_items  = 0;
  int n_hits   = 0;
  int n_evicts = 0;
  int n_caps   = 0;
  int idle_cycles = 0;

  // Work out the result of one item and update the shadow store
  task automatic predict_lookup(input logic [1:0] op, input logic [KW-1:0] k,
                                output lookup_res_t res);
    int found;
    int victim;
    int slot;
    int lim;
    res   = '0;
    found = -1;
    slot  = -1;
    for (int i = 0; i < NSLOT; i++)
      if (found < 0 && shadow_used[i] && shadow_key[i] == k) found = i;
    if (cap_reg == 0) lim = 1;
    else if (cap_reg > NSLOT) lim = NSLOT;
    else lim = int'(cap_reg);
    case (op)
      KIND_ACCESS: begin
        if (found >= 0) begin
          res.hit = 1'b1;
          if (shadow_freq[found] != '1) shadow_freq[found] += 1'b1;
          shadow_age[found] = age_clock;
          age_clock += 1'b1;
          res.count = shadow_freq[found];
        end else begin
          // evict until there is room: lowest count, newest stamp on a tie
          while (shadow_fill >= lim) begin
            victim = -1;
            for (int i = 0; i < NSLOT; i++)
              if (shadow_used[i] && (victim < 0 || shadow_freq[i] < shadow_freq[victim] ||
                  (shadow_freq[i] == shadow_freq[victim] &&
                   shadow_age[i] > shadow_age[victim])))
                victim = i;
            if (victim < 0) begin
              shadow_fill = 0;
              break;
            end
            if (!res.evict_valid) begin
              res.evict_valid = 1'b1;
              res.evict_key   = shadow_key[victim];
            end
            shadow_used[victim] = 1'b0;
            shadow_fill--;
          end
          // lowest free slot takes the new key
          for (int i = 0; i < NSLOT; i++)
            if (slot < 0 && !shadow_used[i]) slot = i;
          if (slot >= 0) begin
            shadow_used[slot] = 1'b1;
            shadow_key[slot]  = k;
            shadow_freq[slot] = 1;
            shadow_age[slot]  = age_clock;
            age_clock += 1'b1;
            shadow_fill++;
            res.count = 1;
          end
        end
      end
      KIND_PEEK: begin
        if (found >= 0) begin
          res.hit   = 1'b1;
          res.count = shadow_freq[found];
        end
      end
      KIND_REMOVE: begin
        if (found >= 0) begin
          res.hit = 1'b1;
          shadow_used[found] = 1'b0;
          if (shadow_fill > 0) shadow_fill--;
        end
      end
      default: ;
    endcase
  endtask

  // Offer one item after a random gap; called and returns at a falling edge
  task automatic send_item(input logic [1:0] op, input logic [KW-1:0] k,
                           input logic typed, input lookup_res_t want);
    int gap;
    lookup_res_t guess;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    kind     = op;
    key      = k;
    do @(posedge clk); while (in_stall);
    predict_lookup(op, k, guess);
    if (typed) pending_results.push_back(want);
    else pending_results.push_back(guess);
    n_items++;
    n_hits   += guess.hit;
    n_evicts += guess.evict_valid;
    @(negedge clk);
  endtask

  // Wait until every outstanding result has come back
  task automatic drain();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // One APB transaction: setup then access
  task automatic apb_xfer(input logic wr, input logic [PDATA_W-1:0] wdata,
                          output logic [PDATA_W-1:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {REG_CAPACITY, 2'b00};
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Change capacity while idle, then read it back
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    logic [PDATA_W-1:0] wdata;
    logic [PDATA_W-1:0] rdata;
    drain();
    wdata = $urandom();
    wdata[CAP_W-1:0] = cap;
    apb_xfer(1'b1, wdata, rdata);
    cap_reg = cap;
    apb_xfer(1'b0, '0, rdata);
    if (rdata[CAP_W-1:0] !== cap_reg) begin
      $display("%0t: capacity readback mismatch: expected %0d, got %0d",
               $time, cap_reg, rdata[CAP_W-1:0]);
      n_errors++;
    end
    n_caps++;
  endtask

  // Output stall: random per transaction, or one long hold-off on request
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        n = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (no_gaps) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 3);
      end
      if (n != 0) begin
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result checker
  always @(posedge clk) begin
    lookup_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: hit %0b evict %0b key %h count %0d",
                 $time, hit, evict_valid, evict_key, entry_count);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit) begin
          $display("%0t: hit mismatch: expected %0b, got %0b", $time, want.hit, hit);
          n_errors++;
        end
        if (evict_valid !== want.evict_valid) begin
          $display("%0t: evict_valid mismatch: expected %0b, got %0b",
                   $time, want.evict_valid, evict_valid);
          n_errors++;
        end
        if (evict_key !== want.evict_key) begin
          $display("%0t: evict_key mismatch: expected %h, got %h",
                   $time, want.evict_key, evict_key);
          n_errors++;
        end
        if (entry_count !== want.count) begin
          $display("%0t: entry_count mismatch: expected %0d, got %0d",
                   $time, want.count, entry_count);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, idle_cycles, pending_results.size());
        $display("tb_lfu_mru_tiebreak_replacement: FAIL");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    int lim;
    int span;
    int base;
    int roll;
    logic [1:0]    op;
    logic [KW-1:0] k;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    kind     = KIND_ACCESS;
    key      = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;

    for (int i = 0; i < NSLOT; i++) begin
      shadow_used[i] = 1'b0;
      shadow_key[i]  = '0;
      shadow_freq[i] = '0;
      shadow_age[i]  = '0;
    end
    age_clock   = '0;
    shadow_fill = 0;
    cap_reg     = CAP_RESET;

    for (int i = 0; i < POOL; i++) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed table
    for (int r = 0; r < N_DIR; r++) begin
      if (DIR_TABLE[r].is_cfg) set_capacity(DIR_TABLE[r].cap);
      else send_item(DIR_TABLE[r].kind, DIR_TABLE[r].key, DIR_TABLE[r].typed,
                     DIR_TABLE[r].want);
    end

    // random phases, each under its own capacity
    for (int p = 0; p < N_PHASES; p++) begin
      set_capacity(PHASE_CAPS[p]);
      if (cap_reg == 0) lim = 1;
      else if (cap_reg > NSLOT) lim = NSLOT;
      else lim = int'(cap_reg);
      // key set a bit larger than capacity so hits and evictions both occur
      span = lim + lim / 2 + 2;
      base = $urandom_range(0, POOL - span);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        if (p == 1 && n == 30) hold_req = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 5) op = KIND_UNUSED;
        else if (roll < 65) op = KIND_ACCESS;
        else if (roll < 82) op = KIND_PEEK;
        else op = KIND_REMOVE;
        if ($urandom_range(0, 19) == 0) k = $urandom();
        else k = key_pool[base + $urandom_range(0, span - 1)];
        send_item(op, k, 1'b0, RES_NONE);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d lookups (%0d hits, %0d evicting misses) across %0d capacity writes,",
             n_items, n_hits, n_evicts, n_caps);
    $display("with out-of-range capacities, capacity cuts and a %0d-cycle output hold-off.",
             HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("tb_lfu_mru_tiebreak_replacement: PASS");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("tb_lfu_mru_tiebreak_replacement: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
rtl/lfu_mru_pkg.sv
rtl/lfu_mru_scan.sv
rtl/lfu_mru_tiebreak_replacement.sv
tb/tb_lfu_mru_tiebreak_replacement.sv
